[rtl/core/wss_pkg.sv]
`timescale 1ns / 1ps

package wss_pkg;

   // Word size of the sortition arithmetic; fields on the ports stay 64 bits.
   localparam int WORD_BITS     = 64;
   localparam int FIELD_BITS    = 64;
   localparam int LO_BITS       = WORD_BITS / 2;
   localparam int HI_BITS       = WORD_BITS - LO_BITS;
   localparam int COMMITTEE_BITS = 16;

   localparam int REQ_DATA_BITS = 192;
   localparam int RSP_DATA_BITS = 72;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 64;

   // Register indexes, taken from paddr[4:3].
   localparam logic [1:0] REG_COMMITTEE = 2'd0;
   localparam logic [1:0] REG_MIN_STAKE = 2'd1;
   localparam logic [1:0] REG_MAX_SLOT  = 2'd2;

   localparam logic [COMMITTEE_BITS-1:0] COMMITTEE_RESET = 16'd16;
   localparam logic [FIELD_BITS-1:0]     MIN_STAKE_RESET = '0;
   localparam logic [FIELD_BITS-1:0]     MAX_SLOT_RESET  = '1;

   typedef struct packed {
      logic [WORD_BITS-1:0] rem;
      logic [WORD_BITS-1:0] dq;
      logic [WORD_BITS-1:0] weight;
      logic [WORD_BITS-1:0] total;
      logic                 zero;
      logic                 elig;
   } div_stage_type;

   typedef struct packed {
      logic [2*LO_BITS-1:0] p00;
      logic [WORD_BITS-1:0] p01;
      logic [WORD_BITS-1:0] p10;
      logic [2*HI_BITS-1:0] p11;
      logic                 zero;
      logic                 elig;
   } mul1_type;

   typedef struct packed {
      logic [2*WORD_BITS-1:0] outer;
      logic [WORD_BITS:0]     mid;
      logic                   zero;
      logic                   elig;
   } mul2_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] prod_hi;
      logic                 zero;
      logic                 elig;
   } mul3_type;

   typedef struct packed {
      logic [FIELD_BITS-1:0] slot;
      logic                  elig;
   } clamp_type;

   // One restoring division step: bring in the next dividend bit and
   // subtract the divisor if it fits. The quotient bit shifts into dq.
   function automatic div_stage_type div_step(div_stage_type s);
      div_stage_type    r;
      logic [WORD_BITS:0] t;
      logic [WORD_BITS:0] d;
      r = s;
      t = {s.rem, s.dq[WORD_BITS-1]};
      d = t - {1'b0, s.weight};
      if (!d[WORD_BITS]) begin
         r.rem = d[WORD_BITS-1:0];
         r.dq  = {s.dq[WORD_BITS-2:0], 1'b1};
      end else begin
         r.rem = t[WORD_BITS-1:0];
         r.dq  = {s.dq[WORD_BITS-2:0], 1'b0};
      end
      return r;
   endfunction

endpackage

[rtl/core/weighted_sortition_slot.sv]
`timescale 1ns / 1ps

// Throughput: one item per cycle while the skid entry is empty; the divider is 64
// pipeline stages, one quotient bit each, followed by four multiply and clamp stages.
// A two-entry output (register plus skid) lets requests keep flowing while
// one result waits. Reset clears all valid bits and loads register defaults.
module weighted_sortition_slot (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // beta_top [63:0], stake_weight [127:64], total_stake [191:128]
   input  logic [wss_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // slot [63:0], is_member [64], zero fill [71:65]
   output logic [wss_pkg::RSP_DATA_BITS-1:0]    rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [wss_pkg::CSR_ADDR_BITS-1:0]    csr_paddr,
   input  logic [wss_pkg::CSR_DATA_BITS-1:0]    csr_pwdata,
   output logic [wss_pkg::CSR_DATA_BITS-1:0]    csr_prdata,
   output logic                                 csr_pready
);
   import wss_pkg::*;

   logic [COMMITTEE_BITS-1:0] committee_ff;
   logic [FIELD_BITS-1:0]     min_stake_ff;
   logic [FIELD_BITS-1:0]     max_slot_ff;
   logic [1:0]                csr_index;
   logic                      csr_write;

   logic                      adv;
   div_stage_type             div_ff  [0:WORD_BITS];
   div_stage_type             div_in  [0:WORD_BITS];
   logic                      div_vld_ff [0:WORD_BITS];
   mul1_type                  mul1_ff, mul1_in;
   mul2_type                  mul2_ff, mul2_in;
   mul3_type                  mul3_ff, mul3_in;
   clamp_type                 clamp_ff, clamp_in;
   logic                      mul1_vld_ff, mul2_vld_ff, mul3_vld_ff, clamp_vld_ff;

   logic                      rsp_vld_ff, skid_vld_ff;
   logic [FIELD_BITS-1:0]     rsp_slot_ff, skid_slot_ff;
   logic                      rsp_member_ff, skid_member_ff;
   logic                      out_member_in;
   logic                      rsp_take;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:3];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         committee_ff <= COMMITTEE_RESET;
         min_stake_ff <= MIN_STAKE_RESET;
         max_slot_ff  <= MAX_SLOT_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_COMMITTEE: committee_ff <= csr_pwdata[COMMITTEE_BITS-1:0];
            REG_MIN_STAKE: min_stake_ff <= csr_pwdata;
            REG_MAX_SLOT:  max_slot_ff  <= csr_pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_COMMITTEE: csr_prdata = {{(CSR_DATA_BITS-COMMITTEE_BITS){1'b0}}, committee_ff};
         REG_MIN_STAKE: csr_prdata = min_stake_ff;
         REG_MAX_SLOT:  csr_prdata = max_slot_ff;
         default:       csr_prdata = '0;
      endcase
   end

   // ---------------- pipeline control ----------------
   // The whole pipe moves unless the skid entry is occupied.
   assign adv        = !skid_vld_ff;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= WORD_BITS; i++) begin
            div_vld_ff[i] <= 1'b0;
         end
         mul1_vld_ff  <= 1'b0;
         mul2_vld_ff  <= 1'b0;
         mul3_vld_ff  <= 1'b0;
         clamp_vld_ff <= 1'b0;
      end else if (adv) begin
         div_vld_ff[0] <= req_tvalid;
         for (int i = 1; i <= WORD_BITS; i++) begin
            div_vld_ff[i] <= div_vld_ff[i-1];
         end
         mul1_vld_ff  <= div_vld_ff[WORD_BITS];
         mul2_vld_ff  <= mul1_vld_ff;
         mul3_vld_ff  <= mul2_vld_ff;
         clamp_vld_ff <= mul3_vld_ff;
      end
   end

   // ---------------- input stage ----------------
   always_comb begin
      logic [FIELD_BITS-1:0] weight_ext;
      div_in[0]        = '0;
      div_in[0].dq     = req_tdata[WORD_BITS-1:0];
      div_in[0].weight = req_tdata[FIELD_BITS+WORD_BITS-1:FIELD_BITS];
      div_in[0].total  = req_tdata[2*FIELD_BITS+WORD_BITS-1:2*FIELD_BITS];
      weight_ext                = '0;
      weight_ext[WORD_BITS-1:0] = div_in[0].weight;
      div_in[0].zero = (div_in[0].weight == '0) || (div_in[0].total == '0);
      div_in[0].elig = (div_in[0].weight != '0) && (weight_ext >= min_stake_ff);
      for (int i = 1; i <= WORD_BITS; i++) begin
         div_in[i] = div_step(div_ff[i-1]);
      end
   end

   // ---------------- multiply and clamp ----------------
   always_comb begin
      logic [LO_BITS-1:0]     a0, b0;
      logic [HI_BITS-1:0]     a1, b1;
      logic [2*WORD_BITS-1:0] sum;
      logic [FIELD_BITS-1:0]  s_ext;
      a0 = div_ff[WORD_BITS].dq[LO_BITS-1:0];
      a1 = div_ff[WORD_BITS].dq[WORD_BITS-1:LO_BITS];
      b0 = div_ff[WORD_BITS].total[LO_BITS-1:0];
      b1 = div_ff[WORD_BITS].total[WORD_BITS-1:LO_BITS];
      mul1_in.p00  = (2*LO_BITS)'(a0) * (2*LO_BITS)'(b0);
      mul1_in.p01  = WORD_BITS'(a0) * WORD_BITS'(b1);
      mul1_in.p10  = WORD_BITS'(a1) * WORD_BITS'(b0);
      mul1_in.p11  = (2*HI_BITS)'(a1) * (2*HI_BITS)'(b1);
      mul1_in.zero = div_ff[WORD_BITS].zero;
      mul1_in.elig = div_ff[WORD_BITS].elig;

      mul2_in.outer = {mul1_ff.p11, mul1_ff.p00};
      mul2_in.mid   = {1'b0, mul1_ff.p01} + {1'b0, mul1_ff.p10};
      mul2_in.zero  = mul1_ff.zero;
      mul2_in.elig  = mul1_ff.elig;

      sum = mul2_ff.outer + ({{(WORD_BITS-1){1'b0}}, mul2_ff.mid} << LO_BITS);
      mul3_in.prod_hi = sum[2*WORD_BITS-1:WORD_BITS];
      mul3_in.zero    = mul2_ff.zero;
      mul3_in.elig    = mul2_ff.elig;

      s_ext                = '0;
      s_ext[WORD_BITS-1:0] = mul3_ff.prod_hi;
      if (mul3_ff.zero || (s_ext >= max_slot_ff)) begin
         clamp_in.slot = max_slot_ff;
      end else begin
         clamp_in.slot = s_ext;
      end
      clamp_in.elig = mul3_ff.elig;

      out_member_in = clamp_ff.elig && (clamp_ff.slot[FIELD_BITS-1:COMMITTEE_BITS] == '0)
                      && (clamp_ff.slot[COMMITTEE_BITS-1:0] < committee_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i <= WORD_BITS; i++) begin
            div_ff[i] <= div_in[i];
         end
         mul1_ff  <= mul1_in;
         mul2_ff  <= mul2_in;
         mul3_ff  <= mul3_in;
         clamp_ff <= clamp_in;
      end
   end

   // ---------------- output register and skid ----------------
   assign rsp_take = rsp_vld_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (skid_vld_ff) begin
         if (rsp_take) begin
            skid_vld_ff <= 1'b0;
         end
      end else if (clamp_vld_ff) begin
         if (rsp_vld_ff && !rsp_take) begin
            skid_vld_ff <= 1'b1;
         end
         rsp_vld_ff <= 1'b1;
      end else if (rsp_take) begin
         rsp_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_vld_ff) begin
         if (rsp_take) begin
            rsp_slot_ff   <= skid_slot_ff;
            rsp_member_ff <= skid_member_ff;
         end
      end else if (clamp_vld_ff) begin
         if (rsp_vld_ff && !rsp_take) begin
            skid_slot_ff   <= clamp_ff.slot;
            skid_member_ff <= out_member_in;
         end else begin
            rsp_slot_ff   <= clamp_ff.slot;
            rsp_member_ff <= out_member_in;
         end
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = {{(RSP_DATA_BITS-FIELD_BITS-1){1'b0}}, rsp_member_ff, rsp_slot_ff};

endmodule
